// ===== src/eefe_pkg.sv =====
// ============================================================================
// eefe_pkg: shared types for the encoder extension and following-error block
// Mode and register codes, and the sample and result word layouts.
// ============================================================================
package eefe_pkg;

    typedef enum logic [1:0] {
        MODE_SAMPLE       = 2'd0,
        MODE_PRESET_TWO   = 2'd1,
        MODE_PRESET_THREE = 2'd2,
        MODE_CLEAR        = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_STEP_RATE  = 2'd0,
        REG_BAND_ONE   = 2'd1,
        REG_BAND_TWO   = 2'd2,
        REG_BAND_THREE = 2'd3
    } cfg_reg_t;

    localparam logic [31:0] ONE_OFFSET = 32'h8000_0000;
    localparam logic [15:0] STEP_RATE_RESET = 16'd1;

    typedef struct packed {
        mode_t              mode;
        logic        [31:0] raw_one;
        logic        [15:0] raw_two;
        logic        [15:0] raw_three;
        logic signed [31:0] steps_one;
        logic signed [31:0] steps_two;
        logic signed [31:0] steps_three;
        logic signed [31:0] preset_value;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] position_one;
        logic signed [31:0] position_two;
        logic signed [31:0] position_three;
        logic        [2:0]  over_band;
        logic               error_latched;
    } result_t;

    // Per-channel control toward a count extender.
    typedef struct packed {
        logic accept;
        logic do_track;
        logic do_preset;
    } ext_ctrl_t;

endpackage

// ===== src/encoder_extend_following_error.sv =====
// ============================================================================
// encoder_extend_following_error: encoder count extension with error check
// Widens two narrow encoder counts to 32 bits, offsets a wide one, and checks
// each channel's position against its commanded steps times the step rate.
// ============================================================================
//
//  channel | signals                                  | moves
//  --------+------------------------------------------+-----------------------
//  sample  | sample_valid, sample_ready, sample_word  | one sample_t word in
//  result  | result_valid, result_ready, result_word  | one result_t word out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| one register write
//
// One sample word is accepted every cycle unless the pipeline is held; each
// gives exactly one result word. The accepting edge loads the first of the
// three register stages of each check lane (multiply, subtract, band compare),
// and the output register follows the third. The count extenders update at
// acceptance, so every sample is tracked in order. Reset clears the extension
// state, sticky latch, valid flags and bands and sets the step rate to one; no
// clearing pass is needed. When the result word is held, the whole pipeline
// holds and sample_ready falls; configuration writes are always taken.
module encoder_extend_following_error
    import eefe_pkg::*;
#(
    parameter int LOW_COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  sample_t     sample_word,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_reg_t    cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers.
    logic [15:0] step_rate_reg;
    logic [30:0] band_one_reg, band_two_reg, band_three_reg;

    // Pipeline control: all stages move together whenever the output
    // register is empty or being drained.
    logic      advance;
    logic      accept;
    logic      v1_reg, v2_reg, v3_reg;
    mode_t     m1_reg, m2_reg, m3_reg;
    logic      is_sample;
    ext_ctrl_t ctrl_two, ctrl_three;

    logic signed [31:0] pos_one, pos_two, pos_three;
    logic signed [31:0] lane_pos_one, lane_pos_two, lane_pos_three;
    logic        [2:0]  over;

    assign cfg_ready    = 1'b1;
    assign advance      = !result_valid || result_ready;
    assign sample_ready = advance;
    assign accept       = sample_valid && advance;
    assign is_sample    = (sample_word.mode == MODE_SAMPLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_rate_reg  <= STEP_RATE_RESET;
            band_one_reg   <= '0;
            band_two_reg   <= '0;
            band_three_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STEP_RATE:  step_rate_reg  <= cfg_data[15:0];
                REG_BAND_ONE:   band_one_reg   <= cfg_data[30:0];
                REG_BAND_TWO:   band_two_reg   <= cfg_data[30:0];
                REG_BAND_THREE: band_three_reg <= cfg_data[30:0];
                default:        step_rate_reg  <= step_rate_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_reg <= sample_word.mode;
            m2_reg <= m1_reg;
            m3_reg <= m2_reg;
        end
    end

    // Only a sample word tracks quadrants; preset words load one channel.
    assign ctrl_two   = '{accept:    accept,
                          do_track:  is_sample,
                          do_preset: sample_word.mode == MODE_PRESET_TWO};
    assign ctrl_three = '{accept:    accept,
                          do_track:  is_sample,
                          do_preset: sample_word.mode == MODE_PRESET_THREE};

    assign pos_one = sample_word.raw_one - ONE_OFFSET;

    eefe_ext #(.LOW_COUNT_WIDTH(LOW_COUNT_WIDTH)) u_ext_two (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_two),
        .raw          (sample_word.raw_two),
        .preset_value (sample_word.preset_value),
        .position     (pos_two)
    );

    eefe_ext #(.LOW_COUNT_WIDTH(LOW_COUNT_WIDTH)) u_ext_three (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_three),
        .raw          (sample_word.raw_three),
        .preset_value (sample_word.preset_value),
        .position     (pos_three)
    );

    // Three check lanes run side by side, one per channel.
    eefe_lane u_lane_one (
        .clk          (clk),
        .en           (advance),
        .check        (is_sample),
        .position     (pos_one),
        .steps        (sample_word.steps_one),
        .rate         (step_rate_reg),
        .band         (band_one_reg),
        .position_out (lane_pos_one),
        .over         (over[0])
    );

    eefe_lane u_lane_two (
        .clk          (clk),
        .en           (advance),
        .check        (is_sample),
        .position     (pos_two),
        .steps        (sample_word.steps_two),
        .rate         (step_rate_reg),
        .band         (band_two_reg),
        .position_out (lane_pos_two),
        .over         (over[1])
    );

    eefe_lane u_lane_three (
        .clk          (clk),
        .en           (advance),
        .check        (is_sample),
        .position     (pos_three),
        .steps        (sample_word.steps_three),
        .rate         (step_rate_reg),
        .band         (band_three_reg),
        .position_out (lane_pos_three),
        .over         (over[2])
    );

    eefe_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .stage_valid (v3_reg),
        .stage_mode  (m3_reg),
        .pos_one     (lane_pos_one),
        .pos_two     (lane_pos_two),
        .pos_three   (lane_pos_three),
        .over        (over),
        .out_valid   (result_valid),
        .out_word    (result_word)
    );

endmodule

// ===== src/eefe_ext.sv =====
// ============================================================================
// eefe_ext: count extender for one narrow encoder channel
// Keeps the upper word and last quadrant, and forms the 32-bit position.
// ============================================================================
module eefe_ext
    import eefe_pkg::*;
#(
    parameter int LOW_COUNT_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ext_ctrl_t          ctrl,
    input  logic        [15:0] raw,
    input  logic signed [31:0] preset_value,
    output logic signed [31:0] position
);

    localparam int UPPER_W = (LOW_COUNT_WIDTH < 32) ? 32 - LOW_COUNT_WIDTH : 1;
    localparam logic [31:0] LOW_MASK = 32'((64'd1 << LOW_COUNT_WIDTH) - 64'd1);

    logic [UPPER_W-1:0] upper_reg, upper_next;
    logic [1:0]         quad_reg, quad_next;
    logic [31:0]        low;
    logic [1:0]         quad_now;
    logic [31:0]        preset_bits;

    assign low         = {16'd0, raw} & LOW_MASK;
    assign quad_now    = low[LOW_COUNT_WIDTH-1 -: 2];
    assign preset_bits = preset_value;

    always_comb
    begin
        upper_next = upper_reg;
        quad_next  = quad_reg;
        if (ctrl.do_preset)
        begin
            upper_next = UPPER_W'(preset_bits >> LOW_COUNT_WIDTH);
            quad_next  = preset_bits[LOW_COUNT_WIDTH-1 -: 2];
        end
        else if (ctrl.do_track)
        begin
            // A pass from the top quadrant to the bottom one is a forward wrap.
            if (quad_now == 2'd0 && quad_reg == 2'd3)
                upper_next = upper_reg + 1'b1;
            else if (quad_now == 2'd3 && quad_reg == 2'd0)
                upper_next = upper_reg - 1'b1;
            quad_next = quad_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= '0;
            quad_reg  <= '0;
        end
        else if (ctrl.accept)
        begin
            upper_reg <= upper_next;
            quad_reg  <= quad_next;
        end
    end

    assign position = (32'(upper_next) << LOW_COUNT_WIDTH) | low;

endmodule

// ===== src/eefe_lane.sv =====
// ============================================================================
// eefe_lane: following-error check for one channel
// Multiply, subtract and band compare over three register stages.
// ============================================================================
module eefe_lane
    import eefe_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic               check,
    input  logic signed [31:0] position,
    input  logic signed [31:0] steps,
    input  logic        [15:0] rate,
    input  logic        [30:0] band,
    output logic signed [31:0] position_out,
    output logic               over
);

    logic signed [48:0] prod_reg;
    logic signed [49:0] diff_reg;
    logic signed [31:0] pos1_reg, pos2_reg, pos3_reg;
    logic               chk1_reg, chk2_reg, over_reg;
    logic signed [49:0] band_s;

    assign band_s = signed'({19'd0, band});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 49'(steps * signed'({1'b0, rate}));
            pos1_reg <= position;
            chk1_reg <= check && (band != '0);

            diff_reg <= 50'(pos1_reg) - 50'(prod_reg);
            pos2_reg <= pos1_reg;
            chk2_reg <= chk1_reg;

            over_reg <= chk2_reg && ((diff_reg > band_s) || (diff_reg < -band_s));
            pos3_reg <= pos2_reg;
        end
    end

    assign position_out = pos3_reg;
    assign over         = over_reg;

endmodule

// ===== src/eefe_merge.sv =====
// ============================================================================
// eefe_merge: combines lane flags into the result word
// Holds the sticky error latch and the output register.
// ============================================================================
module eefe_merge
    import eefe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               stage_valid,
    input  mode_t              stage_mode,
    input  logic signed [31:0] pos_one,
    input  logic signed [31:0] pos_two,
    input  logic signed [31:0] pos_three,
    input  logic        [2:0]  over,
    output logic               out_valid,
    output result_t            out_word
);

    logic    valid_reg, valid_next;
    logic    sticky_reg, sticky_next;
    result_t word_reg;

    always_comb
    begin
        sticky_next = sticky_reg;
        if (stage_valid)
        begin
            if (stage_mode == MODE_CLEAR)
                sticky_next = 1'b0;
            else if (stage_mode == MODE_SAMPLE && over != 3'd0)
                sticky_next = 1'b1;
        end
        valid_next = stage_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            sticky_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg  <= valid_next;
            sticky_reg <= sticky_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg.position_one   <= pos_one;
            word_reg.position_two   <= pos_two;
            word_reg.position_three <= pos_three;
            word_reg.over_band      <= (stage_mode == MODE_SAMPLE) ? over : 3'd0;
            word_reg.error_latched  <= sticky_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== src/eefe_checker.sv =====
// ============================================================================
// eefe_checker: port-level checks for the encoder extension block
// Watches the result channel and the pipeline hold behavior.
// ============================================================================
module eefe_checker
    import eefe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_ready,
    input  logic        result_valid,
    input  logic        result_ready,
    input  result_t     result_word,
    input  logic        cfg_valid,
    input  logic        cfg_ready
);

    // A held result word keeps its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_word))
        else $error("result word changed while held");

    // Any flagged channel must be reflected in the sticky latch.
    a_flag_latched: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_word.over_band == 3'd0 || result_word.error_latched))
        else $error("over_band set without error_latched");

    // With the output register empty, the block must take a sample.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("sample_ready low with empty output");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind encoder_extend_following_error eefe_checker u_eefe_checker (.*);

// ===== verif/tb_encoder_extend_following_error.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_encoder_extend_following_error: self-checking bench for the encoder block
// Drives sample words through the valid/ready channel, predicts every result
// word from its own copy of the count extension, sticky latch and registers,
// and compares each returned word field by field.
// ============================================================================
module tb_encoder_extend_following_error;
    import eefe_pkg::*;

    localparam int LOW_W       = 16;
    localparam int UPPER_W     = 32 - LOW_W;
    // Cycles without any accepted word before the run is declared hung.
    localparam int QUIET_LIMIT = 5000;
    // Length of the deliberate back-pressure stretch on the result side.
    localparam int HOLD_CYCLES = 300;
    localparam int SUB_PHASES  = 4;
    localparam int SUB_WORDS   = 140;

    // Directed rows either carry a register setting or one sample word.
    typedef struct {
        bit          is_cfg;
        logic [15:0] rate;
        logic [30:0] band1;
        logic [30:0] band2;
        logic [30:0] band3;
        sample_t     word;
        bit          typed;
        result_t     want;
    } stim_row_t;

    // Travels with each sample word from the driver to the acceptance point.
    typedef struct {
        bit      typed;
        result_t want;
    } word_note_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_ready;
    sample_t     sample_word  = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result_word;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    cfg_reg_t    cfg_index    = REG_STEP_RATE;
    logic [31:0] cfg_data     = '0;

    // Predictor copy of the block state and registers, all at their reset values.
    logic [UPPER_W-1:0] upper_two_q   = '0;
    logic [1:0]         quad_two_q    = '0;
    logic [UPPER_W-1:0] upper_three_q = '0;
    logic [1:0]         quad_three_q  = '0;
    logic               sticky_q      = 1'b0;
    logic [15:0]        shadow_rate   = STEP_RATE_RESET;
    logic [30:0]        shadow_band1  = '0;
    logic [30:0]        shadow_band2  = '0;
    logic [30:0]        shadow_band3  = '0;

    result_t    pending_results[$];
    word_note_t sample_notes[$];
    stim_row_t  stim_rows[$];

    int mismatches       = 0;
    int words_accepted   = 0;
    int results_seen     = 0;
    int settings_written = 0;
    int tx_idle_pct      = 17;
    int rx_idle_pct      = 62;
    int hold_requests    = 0;
    int holds_done       = 0;
    int hold_left        = 0;
    int quiet_cycles     = 0;

    // Generator's own idea of where the two narrow channels are heading.
    int walk_two   = 0;
    int walk_three = 0;

    result_t    got_word;
    result_t    want_word;
    result_t    predicted;
    word_note_t note;

    encoder_extend_following_error #(
        .LOW_COUNT_WIDTH (LOW_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_word  (sample_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // The upper word moves only on a wrap between the outer quadrants;
    // any other quadrant jump leaves it alone.
    function automatic logic [UPPER_W-1:0] bump_upper(logic [UPPER_W-1:0] upper,
                                                      logic [1:0] was, logic [1:0] now);
        if (now == 2'd0 && was == 2'd3)
            return upper + 1'b1;
        if (now == 2'd3 && was == 2'd0)
            return upper - 1'b1;
        return upper;
    endfunction

    // Following error is formed in 64 bits so nothing wraps. A zero band
    // turns the check off for that channel.
    function automatic bit exceeds(logic [31:0] pos, logic [31:0] steps, logic [30:0] band);
        longint diff;
        if (band == '0)
            return 1'b0;
        diff = longint'($signed(pos)) - longint'($signed(steps)) * longint'(shadow_rate);
        if (diff < 0)
            diff = -diff;
        return diff > longint'(band);
    endfunction

    // Updates the predictor state for one accepted sample word and returns
    // the result word it must produce.
    function automatic result_t extend_and_check(sample_t w);
        result_t    r;
        logic [1:0] now_two;
        logic [1:0] now_three;
        r         = '0;
        now_two   = w.raw_two[LOW_W-1 -: 2];
        now_three = w.raw_three[LOW_W-1 -: 2];
        case (w.mode)
            MODE_SAMPLE:
            begin
                upper_two_q   = bump_upper(upper_two_q, quad_two_q, now_two);
                quad_two_q    = now_two;
                upper_three_q = bump_upper(upper_three_q, quad_three_q, now_three);
                quad_three_q  = now_three;
            end
            MODE_PRESET_TWO:
            begin
                upper_two_q = w.preset_value[31:LOW_W];
                quad_two_q  = w.preset_value[LOW_W-1 -: 2];
            end
            MODE_PRESET_THREE:
            begin
                upper_three_q = w.preset_value[31:LOW_W];
                quad_three_q  = w.preset_value[LOW_W-1 -: 2];
            end
            default:
            begin
                sticky_q = 1'b0;
            end
        endcase
        r.position_one   = w.raw_one - ONE_OFFSET;
        r.position_two   = {upper_two_q, w.raw_two};
        r.position_three = {upper_three_q, w.raw_three};
        // Only plain samples are checked against the bands.
        if (w.mode == MODE_SAMPLE)
        begin
            r.over_band[0] = exceeds(r.position_one, w.steps_one, shadow_band1);
            r.over_band[1] = exceeds(r.position_two, w.steps_two, shadow_band2);
            r.over_band[2] = exceeds(r.position_three, w.steps_three, shadow_band3);
            if (r.over_band != '0)
                sticky_q = 1'b1;
        end
        r.error_latched = sticky_q;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("ERROR at %0t result %0d %s: got %h, expected %h",
                 $realtime, results_seen, what, got, want);
    endtask

    // Everything is sampled at the rising edge. Inputs only move at the
    // falling edge, so the values seen here are the ones the block used.
    // A returned word is checked before the new sample is predicted; the
    // pipeline latency keeps the two from ever belonging to the same item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                got_word = result_word;
                if (pending_results.size() == 0)
                begin
                    flag_mismatch("unexpected word", got_word.position_one, '0);
                end
                else
                begin
                    want_word = pending_results.pop_front();
                    if (got_word.position_one !== want_word.position_one)
                        flag_mismatch("position_one", got_word.position_one,
                                      want_word.position_one);
                    if (got_word.position_two !== want_word.position_two)
                        flag_mismatch("position_two", got_word.position_two,
                                      want_word.position_two);
                    if (got_word.position_three !== want_word.position_three)
                        flag_mismatch("position_three", got_word.position_three,
                                      want_word.position_three);
                    if (got_word.over_band !== want_word.over_band)
                        flag_mismatch("over_band", 32'(got_word.over_band),
                                      32'(want_word.over_band));
                    if (got_word.error_latched !== want_word.error_latched)
                        flag_mismatch("error_latched", 32'(got_word.error_latched),
                                      32'(want_word.error_latched));
                end
                results_seen++;
            end
            if (sample_valid && sample_ready)
            begin
                note      = sample_notes.pop_front();
                predicted = extend_and_check(sample_word);
                // Rows with a hand-written answer are held to that answer,
                // but the predictor still runs so its state stays in step.
                pending_results.push_back(note.typed ? note.want : predicted);
                words_accepted++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_STEP_RATE:  shadow_rate  = cfg_data[15:0];
                    REG_BAND_ONE:   shadow_band1 = cfg_data[30:0];
                    REG_BAND_TWO:   shadow_band2 = cfg_data[30:0];
                    default:        shadow_band3 = cfg_data[30:0];
                endcase
            end
        end
    end

    // Watchdog: any accepted word on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_results.size());
                $display("encoder_extend_following_error: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, plus a long hold when asked for.
    // The hold is counted here so the sender keeps pushing words meanwhile.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (holds_done != hold_requests)
        begin
            result_ready <= 1'b0;
            holds_done   <= holds_done + 1;
            hold_left    <= HOLD_CYCLES;
        end
        else
        begin
            result_ready <= (int'($urandom_range(99)) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sample and register drivers. Every task starts and ends at a falling edge.
    // ------------------------------------------------------------------------

    // Offers one sample word. Valid is dropped only for idle cycles, so back
    // to back words keep it high and only the payload changes.
    task automatic send_word(sample_t w, bit typed, result_t want);
        word_note_t n;
        while (int'($urandom_range(99)) < tx_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        n.typed = typed;
        n.want  = want;
        sample_notes.push_back(n);
        sample_valid <= 1'b1;
        sample_word  <= w;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops offering words until every expected result is back, then lets
    // the pipeline settle.
    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Writes all four registers. Unused upper data bits carry random values
    // so the block is seen to ignore them.
    task automatic write_settings(logic [15:0] rate, logic [30:0] b1, logic [30:0] b2,
                                  logic [30:0] b3);
        logic [31:0] data;
        data = $urandom;
        data[15:0] = rate;
        write_reg(REG_STEP_RATE, data);
        data = $urandom;
        data[30:0] = b1;
        write_reg(REG_BAND_ONE, data);
        data = $urandom;
        data[30:0] = b2;
        write_reg(REG_BAND_TWO, data);
        data = $urandom;
        data[30:0] = b3;
        write_reg(REG_BAND_THREE, data);
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------

    function automatic sample_t mk(mode_t m, logic [31:0] r1, logic [15:0] r2,
                                   logic [15:0] r3, logic [31:0] s1, logic [31:0] s2,
                                   logic [31:0] s3, logic [31:0] pv);
        sample_t w;
        w.mode         = m;
        w.raw_one      = r1;
        w.raw_two      = r2;
        w.raw_three    = r3;
        w.steps_one    = s1;
        w.steps_two    = s2;
        w.steps_three  = s3;
        w.preset_value = pv;
        return w;
    endfunction

    function automatic result_t res(logic [31:0] p1, logic [31:0] p2, logic [31:0] p3,
                                    logic [2:0] ob, logic el);
        result_t r;
        r.position_one   = p1;
        r.position_two   = p2;
        r.position_three = p3;
        r.over_band      = ob;
        r.error_latched  = el;
        return r;
    endfunction

    task automatic add_word(sample_t w, bit typed, result_t want);
        stim_row_t row;
        row        = '{default: '0};
        row.word   = w;
        row.typed  = typed;
        row.want   = want;
        stim_rows.push_back(row);
    endtask

    task automatic add_settings(logic [15:0] rate, logic [30:0] b1, logic [30:0] b2,
                                logic [30:0] b3);
        stim_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.rate   = rate;
        row.band1  = b1;
        row.band2  = b2;
        row.band3  = b3;
        stim_rows.push_back(row);
    endtask

    task automatic build_directed();
        // Reset registers: step rate one, every band off, so no flags.
        // All zero after reset: channel 1 sits at minus the offset.
        add_word(mk(MODE_SAMPLE, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0),
                 1, res(32'h8000_0000, 32'h0, 32'h0, 3'b000, 1'b0));
        // Channel 2 wraps down from quadrant 0 to 3: upper word goes to all ones.
        add_word(mk(MODE_SAMPLE, 32'h8000_0000, 16'hFFFF, 16'h0, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF),
                 1, res(32'h0, 32'hFFFF_FFFF, 32'h0, 3'b000, 1'b0));
        // Channel 2 wraps back up, channel 3 wraps down.
        add_word(mk(MODE_SAMPLE, 32'hFFFF_FFFF, 16'h0, 16'hC000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h0),
                 1, res(32'h7FFF_FFFF, 32'h0, 32'hFFFF_C000, 3'b000, 1'b0));
        // Presets load the upper word and quadrant, positions use this raw count.
        add_word(mk(MODE_PRESET_TWO, 32'h8000_0000, 16'h1234, 16'hC000, 32'hFFFF_FFFF,
                    32'h0, 32'h0, 32'h7FFF_8000),
                 1, res(32'h0, 32'h7FFF_1234, 32'hFFFF_C000, 3'b000, 1'b0));
        add_word(mk(MODE_PRESET_THREE, 32'h8000_0000, 16'h1234, 16'h0, 32'h0,
                    32'hFFFF_FFFF, 32'h0, 32'h8000_0000),
                 1, res(32'h0, 32'h7FFF_1234, 32'h8000_0000, 3'b000, 1'b0));
        // Quadrant 2 to 1 on channel 2 is not a wrap; channel 3 wraps down.
        add_word(mk(MODE_SAMPLE, 32'h8000_0000, 16'h4000, 16'hFFFF, 32'h0, 32'h0,
                    32'hFFFF_FFFF, 32'h0),
                 1, res(32'h0, 32'h7FFF_4000, 32'h7FFF_FFFF, 3'b000, 1'b0));
        // Quadrant 1 to 3 is not a wrap either; channel 3 wraps back up.
        add_word(mk(MODE_SAMPLE, 32'h8000_0000, 16'hC000, 16'h0, 32'h0, 32'h0, 32'h0,
                    32'h0),
                 1, res(32'h0, 32'h7FFF_C000, 32'h8000_0000, 3'b000, 1'b0));
        // Channel 2 upper word rolls from 0x7FFF into the negative half.
        add_word(mk(MODE_SAMPLE, 32'h8000_0000, 16'h0001, 16'h0, 32'h0, 32'h0, 32'h0,
                    32'h0),
                 1, res(32'h0, 32'h8000_0001, 32'h8000_0000, 3'b000, 1'b0));
        add_word(mk(MODE_CLEAR, 32'h8000_0000, 16'h0001, 16'h0, 32'h0, 32'h0, 32'h0,
                    32'h0),
                 1, res(32'h0, 32'h8000_0001, 32'h8000_0000, 3'b000, 1'b0));

        // Largest step rate, tightest and widest bands, channel 3 unchecked.
        add_settings(16'hFFFF, 31'd1, 31'h7FFF_FFFF, 31'd0);
        add_word(mk(MODE_SAMPLE, 32'hFFFF_FFFF, 16'h0001, 16'h0, 32'h7FFF_FFFF, 32'h0,
                    32'h7FFF_FFFF, 32'h0), 0, '0);
        add_word(mk(MODE_SAMPLE, 32'h0, 16'h0001, 16'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h0), 0, '0);
        // Error exactly at the band, then one count past it.
        add_word(mk(MODE_SAMPLE, 32'h8000_0001, 16'h0001, 16'h0, 32'h0, 32'h0,
                    32'h0, 32'h0), 0, '0);
        add_word(mk(MODE_SAMPLE, 32'h8000_0002, 16'h0002, 16'h0, 32'h0, 32'h0,
                    32'h0, 32'h0), 0, '0);
        // Clear and preset words never flag, whatever the steps say.
        add_word(mk(MODE_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h0), 0, '0);
        add_word(mk(MODE_PRESET_TWO, 32'h0, 16'hFFFF, 16'h0, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF), 0, '0);
        add_word(mk(MODE_SAMPLE, 32'h8000_0000, 16'hFFFF, 16'h0, 32'h0, 32'hFFFF_FFFF,
                    32'h0, 32'h0), 0, '0);

        // Zero step rate removes the commanded term altogether.
        add_settings(16'd0, 31'h7FFF_FFFF, 31'd1, 31'd5);
        add_word(mk(MODE_SAMPLE, 32'h8000_0003, 16'h0, 16'h0005, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0), 0, '0);
        add_word(mk(MODE_PRESET_THREE, 32'h8000_0003, 16'h0001, 16'h0006, 32'h0,
                    32'h0, 32'h0, 32'h0000_0005), 0, '0);
        add_word(mk(MODE_SAMPLE, 32'h8000_0003, 16'h0001, 16'h0006, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h0, 32'h0), 0, '0);
        add_word(mk(MODE_SAMPLE, 32'h8000_0003, 16'h0002, 16'h0005, 32'h0, 32'h0,
                    32'h0, 32'h0), 0, '0);
        add_word(mk(MODE_CLEAR, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------------

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(4))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(16, 1));
            3:       return 16'($urandom_range(65535, 1));
            default: return 16'd0;
        endcase
    endfunction

    // Bands scaled to the step rate land near the real following error,
    // so both sides of the compare get hit.
    function automatic logic [30:0] pick_band(logic [15:0] rate);
        case ($urandom_range(5))
            0:       return 31'd0;
            1:       return 31'd1;
            2:       return 31'h7FFF_FFFF;
            3:       return 31'(rate) * 31'($urandom_range(4, 1));
            4:       return 31'($urandom_range(1000, 1));
            default: return 31'($urandom);
        endcase
    endfunction

    // Mostly steps within four of the position divided by the step rate; the rest
    // fully random.
    function automatic logic [31:0] aim_steps(int pos);
        if (shadow_rate == 16'd0 || $urandom_range(3) == 0)
            return $urandom;
        return pos / int'(shadow_rate) + int'($urandom_range(8)) - 4;
    endfunction

    // Narrow channels walk by less than a quadrant per word, which is what a
    // real counter sampled every cycle looks like. One word in ten is noise.
    function automatic sample_t random_sample();
        sample_t w;
        int      pick;
        int      pos_one;
        pick = $urandom_range(99);
        if (pick < 84)
            w.mode = MODE_SAMPLE;
        else if (pick < 90)
            w.mode = MODE_PRESET_TWO;
        else if (pick < 95)
            w.mode = MODE_PRESET_THREE;
        else
            w.mode = MODE_CLEAR;
        w.preset_value = $urandom;
        if (w.mode == MODE_PRESET_TWO)
            walk_two = w.preset_value;
        else if (w.mode == MODE_PRESET_THREE)
            walk_three = w.preset_value;
        else if (w.mode == MODE_SAMPLE)
        begin
            walk_two   = walk_two + int'($urandom_range(24576)) - 12288;
            walk_three = walk_three + int'($urandom_range(24576)) - 12288;
        end
        w.raw_two   = walk_two[15:0];
        w.raw_three = walk_three[15:0];
        if ($urandom_range(9) == 0)
        begin
            w.raw_two   = $urandom;
            w.raw_three = $urandom;
        end
        if ($urandom_range(4) == 0)
            w.raw_one = ONE_OFFSET + 32'($urandom_range(64)) - 32'd32;
        else
            w.raw_one = $urandom;
        pos_one       = int'(w.raw_one - ONE_OFFSET);
        w.steps_one   = aim_steps(pos_one);
        w.steps_two   = aim_steps(walk_two);
        w.steps_three = aim_steps(walk_three);
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [15:0] rate;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        build_directed();
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_cfg)
            begin
                wait_drained();
                write_settings(stim_rows[i].rate, stim_rows[i].band1, stim_rows[i].band2,
                               stim_rows[i].band3);
            end
            else
            begin
                send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);
            end
        end

        // Three idle mixes: receiver-heavy gaps, sender-heavy gaps, then none.
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 62 : 0;
            rx_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 17 : 0;
            for (int sub = 0; sub < SUB_PHASES; sub++)
            begin
                wait_drained();
                rate = pick_rate();
                write_settings(rate, pick_band(rate), pick_band(rate), pick_band(rate));
                // With no idling anywhere, a long receiver hold fills the
                // pipeline and forces the sample side to stall.
                if (phase == 2 && sub == 1)
                    hold_requests++;
                for (int n = 0; n < SUB_WORDS; n++)
                begin
                    if (n == SUB_WORDS / 2)
                        wait_drained();
                    send_word(random_sample(), 1'b0, '0);
                end
            end
        end

        wait_drained();
        repeat (12) @(posedge clk);
        $display("Checked %0d result words for %0d sample words under %0d register settings.",
                 results_seen, words_accepted, settings_written);
        $display("Covered all modes, wraps both ways, presets, latch clears and stalls.");
        if (mismatches == 0)
            $display("encoder_extend_following_error: match");
        else
            $display("encoder_extend_following_error: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/eefe_pkg.sv
src/eefe_ext.sv
src/eefe_lane.sv
src/eefe_merge.sv
src/encoder_extend_following_error.sv
src/eefe_checker.sv
verif/tb_encoder_extend_following_error.sv
